[hw/rtl/twma_pkg.sv]
// ----------------------------------------------------------------------------
// twma_pkg
// Shared types and constants of the ternary weight row accumulator.
// ----------------------------------------------------------------------------
package twma_pkg;

   localparam int ROW_COLUMNS = 64;
   localparam int LANES       = 8;
   localparam int SUM_WIDTH   = 40;
   localparam int GROUPS      = ROW_COLUMNS / LANES;
   localparam int ADDR_WIDTH  = $clog2(GROUPS);

   localparam int VALUE_WIDTH = 16;
   localparam int CODE_WIDTH  = 2;
   localparam int GROUP_WIDTH = 3;
   localparam int PROD_WIDTH  = 2 * VALUE_WIDTH;

   localparam int REQ_DATA_WIDTH = 3 * VALUE_WIDTH;
   localparam int RSP_DATA_WIDTH = LANES * SUM_WIDTH;

   localparam logic [CODE_WIDTH-1:0] CODE_ADD = 2'd2;
   localparam logic [CODE_WIDTH-1:0] CODE_SUB = 2'd0;

   localparam logic [SUM_WIDTH-1:0] SUM_MAX = {1'b0, {(SUM_WIDTH-1){1'b1}}};
   localparam logic [SUM_WIDTH-1:0] SUM_MIN = {1'b1, {(SUM_WIDTH-1){1'b0}}};

   typedef struct packed {
      logic                  rd_en;
      logic [ADDR_WIDTH-1:0] rd_addr;
      logic                  wr_en;
      logic [ADDR_WIDTH-1:0] wr_addr;
      logic                  acc_valid;
   } lane_ctrl_type;

endpackage

[hw/rtl/ternary_weight_matmul_accumulator_unit.sv]
// ----------------------------------------------------------------------------
// ternary_weight_matmul_accumulator_unit
// Accumulates one output row of a ternary weight matrix product with
// block scales; eight lanes update side by side and the row is emitted
// one column group per transaction on the last item.
//
//   channel  dir  handshake            payload
//   req      in   req_tvalid/tready    tdata act,scale,codes; tuser group;
//                                      tlast last_of_row
//   rsp      out  rsp_tvalid/tready    tdata lane0..7 sums; tuser group;
//                                      tlast row_done
//
// an item goes through row read, product register and lane update before the next is taken
// a row end adds a sweep of the lane rams, a read and a load per column group
// rsp has an output register, so a stalled rsp only blocks the next group
// synchronous reset clears control and marks every row as zero
// ----------------------------------------------------------------------------
module ternary_weight_matmul_accumulator_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // activation [15:0], scale [31:16], codes [47:32]
   input  logic [twma_pkg::REQ_DATA_WIDTH-1:0]   req_tdata,
   // column_group [2:0]
   input  logic [twma_pkg::GROUP_WIDTH-1:0]      req_tuser,
   input  logic                                  req_tlast,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // lane0_sum [39:0], lane1_sum [79:40] ... lane7_sum [319:280]
   output logic [twma_pkg::RSP_DATA_WIDTH-1:0]   rsp_tdata,
   // out_group [2:0]
   output logic [twma_pkg::GROUP_WIDTH-1:0]      rsp_tuser,
   output logic                                  rsp_tlast
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_UPD,
      ST_EMIT_RD,
      ST_EMIT_LD
   } state_type;

   localparam logic [twma_pkg::ADDR_WIDTH-1:0] LAST_GROUP =
      twma_pkg::ADDR_WIDTH'(twma_pkg::GROUPS - 1);

   state_type                                   state_ff, state_in;
   logic signed [twma_pkg::VALUE_WIDTH-1:0]     act_ff, act_in;
   logic signed [twma_pkg::VALUE_WIDTH-1:0]     scale_ff, scale_in;
   logic [2*twma_pkg::LANES-1:0]                codes_ff, codes_in;
   logic [twma_pkg::GROUP_WIDTH-1:0]            group_ff, group_in;
   logic                                        last_ff, last_in;
   logic signed [twma_pkg::PROD_WIDTH-1:0]      prod_ff, prod_in;
   logic [twma_pkg::GROUPS-1:0]                 valid_ff, valid_in;
   logic                                        rd_valid_ff, rd_valid_in;
   logic [twma_pkg::ADDR_WIDTH-1:0]             emit_cnt_ff, emit_cnt_in;
   logic                                        rsp_valid_ff, rsp_valid_in;
   logic [twma_pkg::RSP_DATA_WIDTH-1:0]         rsp_data_ff, rsp_data_in;
   logic [twma_pkg::GROUP_WIDTH-1:0]            rsp_group_ff, rsp_group_in;
   logic                                        rsp_last_ff, rsp_last_in;

   logic                                        accept;
   logic                                        in_range;
   logic                                        load;
   twma_pkg::lane_ctrl_type                     ctrl;
   logic [twma_pkg::SUM_WIDTH-1:0]              lane_sum [twma_pkg::LANES];

   assign accept   = req_tvalid && req_tready;
   assign in_range = int'(group_ff) < twma_pkg::GROUPS;
   assign load     = (state_ff == ST_EMIT_LD) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      ctrl.rd_en     = accept || (state_ff == ST_EMIT_RD);
      ctrl.rd_addr   = (state_ff == ST_EMIT_RD) ? emit_cnt_ff
                                                : req_tuser[twma_pkg::ADDR_WIDTH-1:0];
      ctrl.wr_en     = (state_ff == ST_UPD) && in_range;
      ctrl.wr_addr   = group_ff[twma_pkg::ADDR_WIDTH-1:0];
      ctrl.acc_valid = rd_valid_ff;
   end

   for (genvar i = 0; i < twma_pkg::LANES; i++) begin : g_lane
      twma_lane u_lane (
         .clock    (clock),
         .ctrl     (ctrl),
         .code     (codes_ff[2*i +: 2]),
         .prod     (prod_ff),
         .lane_sum (lane_sum[i])
      );
   end

   always_comb begin
      state_in     = state_ff;
      act_in       = act_ff;
      scale_in     = scale_ff;
      codes_in     = codes_ff;
      group_in     = group_ff;
      last_in      = last_ff;
      prod_in      = prod_ff;
      valid_in     = valid_ff;
      rd_valid_in  = ctrl.rd_en ? valid_ff[ctrl.rd_addr] : rd_valid_ff;
      emit_cnt_in  = emit_cnt_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_group_in = rsp_group_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               act_in   = req_tdata[0 +: twma_pkg::VALUE_WIDTH];
               scale_in = req_tdata[twma_pkg::VALUE_WIDTH +: twma_pkg::VALUE_WIDTH];
               codes_in = req_tdata[2*twma_pkg::VALUE_WIDTH +: twma_pkg::VALUE_WIDTH];
               group_in = req_tuser;
               last_in  = req_tlast;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            prod_in  = act_ff * scale_ff;
            state_in = ST_UPD;
         end
         ST_UPD: begin
            if (ctrl.wr_en) begin
               valid_in[ctrl.wr_addr] = 1'b1;
            end
            emit_cnt_in = '0;
            state_in    = last_ff ? ST_EMIT_RD : ST_IDLE;
         end
         ST_EMIT_RD: begin
            state_in = ST_EMIT_LD;
         end
         ST_EMIT_LD: begin
            if (load) begin
               for (int i = 0; i < twma_pkg::LANES; i++) begin
                  rsp_data_in[i*twma_pkg::SUM_WIDTH +: twma_pkg::SUM_WIDTH] = lane_sum[i];
               end
               rsp_group_in = twma_pkg::GROUP_WIDTH'(emit_cnt_ff);
               rsp_last_in  = (emit_cnt_ff == LAST_GROUP);
               rsp_valid_in = 1'b1;
               emit_cnt_in  = emit_cnt_ff + 1'b1;
               if (emit_cnt_ff == LAST_GROUP) begin
                  valid_in = '0;
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_EMIT_RD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         rd_valid_ff  <= 1'b0;
         emit_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         rd_valid_ff  <= rd_valid_in;
         emit_cnt_ff  <= emit_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      act_ff       <= act_in;
      scale_ff     <= scale_in;
      codes_ff     <= codes_in;
      group_ff     <= group_in;
      last_ff      <= last_in;
      prod_ff      <= prod_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_group_ff <= rsp_group_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_group_ff;
   assign rsp_tlast  = rsp_last_ff;

   // row cleared once the last group is loaded
   a_row_clear: assert property (@(posedge clock) disable iff (reset)
      load && (emit_cnt_ff == LAST_GROUP) |=> valid_ff == '0)
      else $error("rows not cleared after row emission");

   // row_done only with the last group
   a_done_group: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tuser == twma_pkg::GROUP_WIDTH'(twma_pkg::GROUPS - 1))
      else $error("row_done on a group other than the last");

   // an in-range update marks its row
   a_row_mark: assert property (@(posedge clock) disable iff (reset)
      ctrl.wr_en |=> valid_ff[$past(ctrl.wr_addr)])
      else $error("updated row not marked valid");

   // new results come only from the emission sweep
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid ##1 rsp_tvalid |-> $past(state_ff) == ST_EMIT_LD)
      else $error("result raised outside the emission sweep");

endmodule

[hw/rtl/twma_ram.sv]
// ----------------------------------------------------------------------------
// twma_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module twma_ram #(
   parameter int WIDTH = 40,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/twma_lane.sv]
// ----------------------------------------------------------------------------
// twma_lane
// One accumulator lane: row storage for one column of every group and a
// saturating add or subtract of the shared product.
// ----------------------------------------------------------------------------
module twma_lane (
   input  logic                                     clock,
   input  twma_pkg::lane_ctrl_type                  ctrl,
   input  logic [twma_pkg::CODE_WIDTH-1:0]          code,
   input  logic signed [twma_pkg::PROD_WIDTH-1:0]   prod,
   output logic [twma_pkg::SUM_WIDTH-1:0]           lane_sum
);

   logic [twma_pkg::SUM_WIDTH-1:0]        rd_data;
   logic [twma_pkg::SUM_WIDTH-1:0]        acc;
   logic signed [twma_pkg::SUM_WIDTH:0]   prod_ext;
   logic signed [twma_pkg::SUM_WIDTH:0]   delta;
   logic signed [twma_pkg::SUM_WIDTH:0]   sum_wide;
   logic [twma_pkg::SUM_WIDTH-1:0]        sum_sat;

   twma_ram #(
      .WIDTH (twma_pkg::SUM_WIDTH),
      .DEPTH (twma_pkg::GROUPS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ctrl.wr_en),
      .wr_addr (ctrl.wr_addr),
      .wr_data (sum_sat),
      .rd_en   (ctrl.rd_en),
      .rd_addr (ctrl.rd_addr),
      .rd_data (rd_data)
   );

   // row never written since the last clear reads as zero
   assign acc = ctrl.acc_valid ? rd_data : '0;

   assign prod_ext = {{(twma_pkg::SUM_WIDTH + 1 - twma_pkg::PROD_WIDTH){prod[twma_pkg::PROD_WIDTH-1]}},
                      prod};

   always_comb begin
      case (code)
         twma_pkg::CODE_ADD: delta = prod_ext;
         twma_pkg::CODE_SUB: delta = -prod_ext;
         default:            delta = '0;
      endcase
   end

   assign sum_wide = $signed({acc[twma_pkg::SUM_WIDTH-1], acc}) + delta;

   always_comb begin
      if (sum_wide[twma_pkg::SUM_WIDTH] != sum_wide[twma_pkg::SUM_WIDTH-1]) begin
         sum_sat = sum_wide[twma_pkg::SUM_WIDTH] ? twma_pkg::SUM_MIN : twma_pkg::SUM_MAX;
      end else begin
         sum_sat = sum_wide[twma_pkg::SUM_WIDTH-1:0];
      end
   end

   assign lane_sum = acc;

endmodule
